FILE: sv/lgmt_pkg.sv
// Shared types, codes and helpers of the link group membership table.
package lgmt_pkg;

    localparam int GROUPS_DEF = 32;
    localparam int SLOTS_DEF  = 8;

    localparam int MODE_W   = 2;
    localparam int GID_W    = 6;
    localparam int PORT_W   = 8;
    localparam int SPEED_W  = 14;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = 14;
    localparam int SIDX_W   = 3;
    localparam int COUNT_W  = 4;
    localparam int KEY_SHIFT = 8;

    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEY = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_10    = 14'd10;
    localparam logic [SPEED_W-1:0] SPEED_100   = 14'd100;
    localparam logic [SPEED_W-1:0] SPEED_1000  = 14'd1000;
    localparam logic [SPEED_W-1:0] SPEED_10000 = 14'd10000;

    localparam logic [SIDX_W-1:0] SIDX_NONE  = 3'd0;
    localparam logic [SIDX_W-1:0] SIDX_10    = 3'd1;
    localparam logic [SIDX_W-1:0] SIDX_100   = 3'd2;
    localparam logic [SIDX_W-1:0] SIDX_1000  = 3'd3;
    localparam logic [SIDX_W-1:0] SIDX_10000 = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DONE
    } t_state;

    function automatic logic [SIDX_W-1:0] speed_index(
        input logic [SPEED_W-1:0] speed,
        input logic               duplex
    );
        logic [SIDX_W-1:0] idx;
        idx = SIDX_NONE;
        if (duplex) begin
            case (speed)
                SPEED_10:    idx = SIDX_10;
                SPEED_100:   idx = SIDX_100;
                SPEED_1000:  idx = SIDX_1000;
                SPEED_10000: idx = SIDX_10000;
                default:     idx = SIDX_NONE;
            endcase
        end
        return idx;
    endfunction

endpackage

FILE: sv/link_group_membership_table_core.sv
// Top level of the link group membership table: sequencer, valid bits, row RAM.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_mode i_group_id i_port_index
//          |           |                           | i_speed_mbps i_full_duplex
//  out     | output    | o_out_valid / i_out_ready | o_status o_oper_key
//
// One transaction at a time. Add: accept, one RAM read, a write-back when a slot is
// free, then the result register. Delete and key: one row of the group RAM per cycle,
// groups in order, until a match or the last row, so 1..GROUPS rows are scanned.
// Adds with a bad group id and unused modes go from accept straight to the result
// register. Reset clears valid bits and counts. A stalled output holds the result; a new
// transaction is taken meanwhile and waits in its last state for the output register.
module link_group_membership_table_core #(
    parameter int GROUPS = lgmt_pkg::GROUPS_DEF,
    parameter int SLOTS_PER_GROUP = lgmt_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lgmt_pkg::MODE_W-1:0]   i_mode,
    input  logic [lgmt_pkg::GID_W-1:0]    i_group_id,
    input  logic [lgmt_pkg::PORT_W-1:0]   i_port_index,
    input  logic [lgmt_pkg::SPEED_W-1:0]  i_speed_mbps,
    input  logic                          i_full_duplex,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lgmt_pkg::STATUS_W-1:0] o_status,
    output logic [lgmt_pkg::KEY_W-1:0]    o_oper_key
);

    localparam int ROW_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SL_W  = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
    localparam int ROW_BITS = SLOTS_PER_GROUP * lgmt_pkg::PORT_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GROUPS - 1);

    lgmt_pkg::t_state r_state, n_state;

    logic [lgmt_pkg::MODE_W-1:0]   r_mode;
    logic [lgmt_pkg::PORT_W-1:0]   r_port;
    logic [lgmt_pkg::SIDX_W-1:0]   r_sidx;
    logic [ROW_W-1:0]              r_row;
    logic [lgmt_pkg::STATUS_W-1:0] r_res_status;
    logic [lgmt_pkg::KEY_W-1:0]    r_res_key;
    logic                          r_out_valid;
    logic [lgmt_pkg::STATUS_W-1:0] r_out_status;
    logic [lgmt_pkg::KEY_W-1:0]    r_out_key;

    logic [GROUPS-1:0][SLOTS_PER_GROUP-1:0] r_used;
    logic [lgmt_pkg::COUNT_W-1:0]           r_count [GROUPS];

    logic                in_acc;
    logic                gid_ok;
    logic                is_last;
    logic                ram_en;
    logic                ram_we;
    logic [ROW_W-1:0]    ram_addr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [ROW_BITS-1:0] ram_rdata;
    logic                match_any;
    logic [SL_W-1:0]     match_idx;
    logic                free_any;
    logic [SL_W-1:0]     free_idx;
    logic                do_add;
    logic                do_del;
    logic                key_hit;
    logic                scan_end;
    logic                out_load;
    logic [ROW_W:0]      grp_num;

    lgmt_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(GROUPS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_en   (ram_en),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    lgmt_row_scan #(
        .SLOTS(SLOTS_PER_GROUP)
    ) u_scan (
        .i_row      (ram_rdata),
        .i_used     (r_used[r_row]),
        .i_port     (r_port),
        .o_match_any(match_any),
        .o_match_idx(match_idx),
        .o_free_any (free_any),
        .o_free_idx (free_idx)
    );

    assign in_acc  = i_in_valid && o_in_ready;
    assign gid_ok  = (int'(i_group_id) >= 1) && (int'(i_group_id) <= GROUPS);
    assign is_last = (r_row == LAST_ROW);
    assign grp_num = {1'b0, r_row} + (ROW_W + 1)'(1);

    always_comb begin
        for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
            ram_wdata[s*lgmt_pkg::PORT_W +: lgmt_pkg::PORT_W] =
                (SL_W'(s) == free_idx) ? r_port
                                       : ram_rdata[s*lgmt_pkg::PORT_W +: lgmt_pkg::PORT_W];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgmt_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if ((i_mode == lgmt_pkg::MODE_ADD && gid_ok) ||
                        i_mode == lgmt_pkg::MODE_DEL || i_mode == lgmt_pkg::MODE_KEY) begin
                        n_state = lgmt_pkg::ST_READ;
                    end else begin
                        n_state = lgmt_pkg::ST_DONE;
                    end
                end
            end
            lgmt_pkg::ST_READ: n_state = lgmt_pkg::ST_SCAN;
            lgmt_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = lgmt_pkg::ST_DONE;
                end
            end
            lgmt_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = lgmt_pkg::ST_IDLE;
                end
            end
            default: n_state = lgmt_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = r_row;
        do_add     = 1'b0;
        do_del     = 1'b0;
        key_hit    = 1'b0;
        scan_end   = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            lgmt_pkg::ST_IDLE: o_in_ready = 1'b1;
            lgmt_pkg::ST_READ: ram_en = 1'b1;
            lgmt_pkg::ST_SCAN: begin
                case (r_mode)
                    lgmt_pkg::MODE_ADD: begin
                        scan_end = 1'b1;
                        do_add   = free_any;
                        ram_en   = free_any;
                        ram_we   = free_any;
                    end
                    lgmt_pkg::MODE_DEL: begin
                        do_del   = match_any;
                        scan_end = match_any || is_last;
                    end
                    default: begin
                        key_hit  = match_any;
                        scan_end = match_any || is_last;
                    end
                endcase
                if (!scan_end) begin
                    ram_en   = 1'b1;
                    ram_addr = r_row + ROW_W'(1);
                end
            end
            lgmt_pkg::ST_DONE: out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lgmt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            for (int g = 0; g < GROUPS; g++) begin
                r_count[g] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (do_add) begin
                r_used[r_row][free_idx] <= 1'b1;
                r_count[r_row] <= r_count[r_row] + lgmt_pkg::COUNT_W'(1);
            end
            if (do_del) begin
                r_used[r_row][match_idx] <= 1'b0;
                r_count[r_row] <= r_count[r_row] - lgmt_pkg::COUNT_W'(1);
            end
        end
    end

    // transaction fields and result; no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode       <= i_mode;
            r_port       <= i_port_index;
            r_sidx       <= lgmt_pkg::speed_index(i_speed_mbps, i_full_duplex);
            r_res_key    <= '0;
            if (i_mode == lgmt_pkg::MODE_ADD) begin
                r_row        <= ROW_W'(i_group_id - lgmt_pkg::GID_W'(1));
                r_res_status <= gid_ok ? lgmt_pkg::STATUS_OK : lgmt_pkg::STATUS_FULL;
            end else begin
                r_row        <= '0;
                r_res_status <= lgmt_pkg::STATUS_OK;
            end
        end else if (r_state == lgmt_pkg::ST_SCAN) begin
            if (!scan_end) begin
                r_row <= r_row + ROW_W'(1);
            end
            case (r_mode)
                lgmt_pkg::MODE_ADD: begin
                    r_res_status <= free_any ? lgmt_pkg::STATUS_OK : lgmt_pkg::STATUS_FULL;
                end
                lgmt_pkg::MODE_DEL: begin
                    r_res_status <= match_any ? lgmt_pkg::STATUS_OK
                                              : lgmt_pkg::STATUS_NOT_FOUND;
                end
                default: begin
                    if (key_hit) begin
                        r_res_key <= lgmt_pkg::KEY_W'((32'(grp_num) << lgmt_pkg::KEY_SHIFT)
                                                     | 32'(r_sidx));
                    end else begin
                        r_res_key <= lgmt_pkg::KEY_W'(r_sidx);
                    end
                end
            endcase
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_key    <= r_res_key;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_oper_key  = r_out_key;

endmodule

FILE: sv/lgmt_ram.sv
// Generic single-port synchronous RAM with registered read.
module lgmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lgmt_row_scan.sv
// Per-row search: first slot holding a port and first empty slot.
module lgmt_row_scan #(
    parameter int SLOTS = lgmt_pkg::SLOTS_DEF,
    localparam int SL_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic [SLOTS*lgmt_pkg::PORT_W-1:0] i_row,
    input  logic [SLOTS-1:0]                  i_used,
    input  logic [lgmt_pkg::PORT_W-1:0]       i_port,
    output logic                              o_match_any,
    output logic [SL_W-1:0]                   o_match_idx,
    output logic                              o_free_any,
    output logic [SL_W-1:0]                   o_free_idx
);

    logic [SLOTS-1:0] w_match;

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            w_match[s] = i_used[s] &&
                (i_row[s*lgmt_pkg::PORT_W +: lgmt_pkg::PORT_W] == i_port);
        end
    end

    always_comb begin
        o_match_any = 1'b0;
        o_match_idx = '0;
        o_free_any  = 1'b0;
        o_free_idx  = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (w_match[s]) begin
                o_match_any = 1'b1;
                o_match_idx = SL_W'(s);
            end
            if (!i_used[s]) begin
                o_free_any = 1'b1;
                o_free_idx = SL_W'(s);
            end
        end
    end

endmodule

FILE: sv/lgmt_checker.sv
// Port-level assertions for the link group membership table, with bind.
module lgmt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [lgmt_pkg::STATUS_W-1:0] o_status,
    input logic [lgmt_pkg::KEY_W-1:0]    o_oper_key
);

    localparam logic [lgmt_pkg::STATUS_W-1:0] STATUS_BAD = 2'd3;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_oper_key))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != STATUS_BAD)
        else $error("unused status code");

    a_err_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != lgmt_pkg::STATUS_OK |-> o_oper_key == '0)
        else $error("key reported with error status");

    a_speed_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_oper_key[7:0] <= 8'(lgmt_pkg::SIDX_10000))
        else $error("speed index out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

endmodule

bind link_group_membership_table_core lgmt_checker u_lgmt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_status   (o_status),
    .o_oper_key (o_oper_key)
);

FILE: dv/link_group_membership_table_core_tb.sv
// Self-checking testbench for the link group membership table core.
`timescale 1ns / 100ps

module link_group_membership_table_core_tb;

    localparam int NGROUPS      = lgmt_pkg::GROUPS_DEF;
    localparam int NSLOTS       = lgmt_pkg::SLOTS_DEF;
    localparam int RANDOM_CMDS  = 640;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLDOFF_AT   = 220;
    localparam int HOLDOFF_LEN  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam logic [lgmt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [lgmt_pkg::MODE_W-1:0]  mode;
        logic [lgmt_pkg::GID_W-1:0]   gid;
        logic [lgmt_pkg::PORT_W-1:0]  port;
        logic [lgmt_pkg::SPEED_W-1:0] speed;
        logic                         duplex;
        bit                           hold;
    } t_link_cmd;

    typedef struct {
        logic [lgmt_pkg::STATUS_W-1:0] status;
        logic [lgmt_pkg::KEY_W-1:0]    key;
    } t_link_reply;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic [lgmt_pkg::MODE_W-1:0]   i_mode = '0;
    logic [lgmt_pkg::GID_W-1:0]    i_group_id = '0;
    logic [lgmt_pkg::PORT_W-1:0]   i_port_index = '0;
    logic [lgmt_pkg::SPEED_W-1:0]  i_speed_mbps = '0;
    logic                          i_full_duplex = 1'b0;
    logic                          i_out_ready = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [lgmt_pkg::STATUS_W-1:0] o_status;
    logic [lgmt_pkg::KEY_W-1:0]    o_oper_key;

    // shadow membership table
    logic [lgmt_pkg::PORT_W-1:0]  mbr_port [NGROUPS*NSLOTS];
    bit                           mbr_used [NGROUPS*NSLOTS];
    logic [lgmt_pkg::COUNT_W-1:0] mbr_count [NGROUPS];

    t_link_cmd   cmd_q [$];
    t_link_reply replies_due [$];
    t_link_cmd   cur_cmd;

    int          total_cmds = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          n_errors = 0;
    int          n_cycles = 0;
    int          n_add = 0, n_del = 0, n_key = 0, n_unused = 0;
    int          n_full = 0, n_not_found = 0, n_key_hit = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned holdoff_left = 0;
    bit          holdoff_done = 1'b0;

    link_group_membership_table_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_group_id    (i_group_id),
        .i_port_index  (i_port_index),
        .i_speed_mbps  (i_speed_mbps),
        .i_full_duplex (i_full_duplex),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_oper_key    (o_oper_key)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [lgmt_pkg::SIDX_W-1:0] link_speed_code(
        input logic [lgmt_pkg::SPEED_W-1:0] mbps,
        input logic                         fdx
    );
        if (!fdx) return lgmt_pkg::SIDX_NONE;
        case (mbps)
            lgmt_pkg::SPEED_10:    return lgmt_pkg::SIDX_10;
            lgmt_pkg::SPEED_100:   return lgmt_pkg::SIDX_100;
            lgmt_pkg::SPEED_1000:  return lgmt_pkg::SIDX_1000;
            lgmt_pkg::SPEED_10000: return lgmt_pkg::SIDX_10000;
            default:               return lgmt_pkg::SIDX_NONE;
        endcase
    endfunction

    // Updates the shadow table and returns the reply the block owes.
    function automatic t_link_reply apply_membership(input t_link_cmd c);
        t_link_reply r;
        int          base;
        int          hit_group;
        bit          done;
        r.status  = lgmt_pkg::STATUS_OK;
        r.key     = '0;
        hit_group = 0;
        done      = 1'b0;
        case (c.mode)
            lgmt_pkg::MODE_ADD: begin
                r.status = lgmt_pkg::STATUS_FULL;
                if (c.gid >= 1 && c.gid <= NGROUPS) begin
                    base = (int'(c.gid) - 1) * NSLOTS;
                    for (int s = 0; s < NSLOTS && !done; s++) begin
                        if (!mbr_used[base+s]) begin
                            mbr_used[base+s] = 1'b1;
                            mbr_port[base+s] = c.port;
                            mbr_count[int'(c.gid)-1] = mbr_count[int'(c.gid)-1] + 1'b1;
                            r.status = lgmt_pkg::STATUS_OK;
                            done = 1'b1;
                        end
                    end
                end
            end
            lgmt_pkg::MODE_DEL: begin
                r.status = lgmt_pkg::STATUS_NOT_FOUND;
                for (int g = 0; g < NGROUPS && !done; g++) begin
                    for (int s = 0; s < NSLOTS && !done; s++) begin
                        if (mbr_used[g*NSLOTS+s] && mbr_port[g*NSLOTS+s] == c.port) begin
                            mbr_used[g*NSLOTS+s] = 1'b0;
                            mbr_count[g] = mbr_count[g] - 1'b1;
                            r.status = lgmt_pkg::STATUS_OK;
                            done = 1'b1;
                        end
                    end
                end
            end
            lgmt_pkg::MODE_KEY: begin
                for (int g = 0; g < NGROUPS && hit_group == 0; g++) begin
                    for (int s = 0; s < NSLOTS && hit_group == 0; s++) begin
                        if (mbr_used[g*NSLOTS+s] && mbr_port[g*NSLOTS+s] == c.port)
                            hit_group = g + 1;
                    end
                end
                r.key = lgmt_pkg::KEY_W'((hit_group << lgmt_pkg::KEY_SHIFT)
                                         | int'(link_speed_code(c.speed, c.duplex)));
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int unsigned idle_span(input bit calm);
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_cmd(
        input logic [lgmt_pkg::MODE_W-1:0]  m,
        input logic [lgmt_pkg::GID_W-1:0]   g,
        input logic [lgmt_pkg::PORT_W-1:0]  p,
        input logic [lgmt_pkg::SPEED_W-1:0] s,
        input logic                         d
    );
        t_link_cmd c;
        c.mode   = m;
        c.gid    = g;
        c.port   = p;
        c.speed  = s;
        c.duplex = d;
        c.hold   = 1'b0;
        cmd_q.push_back(c);
        total_cmds++;
    endtask

    // marker: sender waits here until every reply is in
    task automatic queue_hold();
        t_link_cmd c;
        c = '{default: '0};
        c.hold = 1'b1;
        cmd_q.push_back(c);
    endtask

    // driver
    always @(posedge i_clk) begin : drive
        t_link_cmd   c;
        t_link_reply r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r = apply_membership(cur_cmd);
                replies_due.push_back(r);
                n_accepted <= n_accepted + 1;
                case (cur_cmd.mode)
                    lgmt_pkg::MODE_ADD: n_add++;
                    lgmt_pkg::MODE_DEL: n_del++;
                    lgmt_pkg::MODE_KEY: n_key++;
                    default:            n_unused++;
                endcase
                if (cur_cmd.mode == lgmt_pkg::MODE_ADD && r.status == lgmt_pkg::STATUS_FULL)
                    n_full++;
                if (r.status == lgmt_pkg::STATUS_NOT_FOUND) n_not_found++;
                if (cur_cmd.mode == lgmt_pkg::MODE_KEY && (r.key >> lgmt_pkg::KEY_SHIFT) != 0)
                    n_key_hit++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (cmd_q.size() > 0 && cmd_q[0].hold) begin
                    i_in_valid <= 1'b0;
                    if (replies_due.size() == 0) void'(cmd_q.pop_front());
                end else if (cmd_q.size() > 0) begin
                    c = cmd_q.pop_front();
                    cur_cmd       = c;
                    i_in_valid    <= 1'b1;
                    i_mode        <= c.mode;
                    i_group_id    <= c.gid;
                    i_port_index  <= c.port;
                    i_speed_mbps  <= c.speed;
                    i_full_duplex <= c.duplex;
                    send_gap = idle_span((n_accepted / 48) % 3 == 2);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_ready <= 1'b0;
        end else if (!holdoff_done && n_accepted >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_LEN;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left = idle_span((n_results / 40) % 3 == 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin : check
        t_link_reply want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            n_results <= n_results + 1;
            if (replies_due.size() == 0) begin
                $error("unexpected transaction: status %0d oper_key %0d", o_status, o_oper_key);
                n_errors++;
            end else begin
                want = replies_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_errors++;
                end
                if (o_oper_key !== want.key) begin
                    $error("oper_key: expected 0x%0h, got 0x%0h", want.key, o_oper_key);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [lgmt_pkg::PORT_W-1:0]  pool [16];
        logic [lgmt_pkg::GID_W-1:0]   hot [4];
        logic [lgmt_pkg::SPEED_W-1:0] known [4];
        logic [lgmt_pkg::PORT_W-1:0]  p;
        logic [lgmt_pkg::GID_W-1:0]   g;
        logic [lgmt_pkg::SPEED_W-1:0] s;
        int unsigned                  roll;
        int unsigned                  pick;
        int unsigned                  add_share;

        for (int k = 0; k < NGROUPS*NSLOTS; k++) begin
            mbr_used[k] = 1'b0;
            mbr_port[k] = '0;
        end
        for (int k = 0; k < NGROUPS; k++) mbr_count[k] = '0;

        // directed
        queue_cmd(lgmt_pkg::MODE_KEY, 6'd0, 8'h00, lgmt_pkg::SPEED_10000, 1'b1);
        queue_cmd(lgmt_pkg::MODE_DEL, 6'd0, 8'h00, 14'h0, 1'b0);
        queue_cmd(lgmt_pkg::MODE_ADD, 6'd1, 8'h00, 14'h0, 1'b0);
        queue_cmd(lgmt_pkg::MODE_ADD, 6'd32, 8'hFF, 14'h3FFF, 1'b1);
        queue_cmd(lgmt_pkg::MODE_ADD, 6'd0, 8'h05, 14'h0, 1'b0);
        queue_cmd(lgmt_pkg::MODE_ADD, 6'd33, 8'h05, 14'h0, 1'b0);
        queue_cmd(lgmt_pkg::MODE_ADD, 6'd63, 8'h05, 14'h0, 1'b0);
        queue_cmd(lgmt_pkg::MODE_KEY, 6'd0, 8'hFF, lgmt_pkg::SPEED_10, 1'b1);
        queue_cmd(lgmt_pkg::MODE_KEY, 6'd0, 8'h00, lgmt_pkg::SPEED_100, 1'b1);
        queue_cmd(lgmt_pkg::MODE_KEY, 6'd0, 8'h00, lgmt_pkg::SPEED_1000, 1'b0);
        queue_cmd(lgmt_pkg::MODE_KEY, 6'd0, 8'h00, 14'h3FFF, 1'b1);
        queue_cmd(lgmt_pkg::MODE_KEY, 6'd0, 8'h00, 14'h0, 1'b1);
        queue_cmd(lgmt_pkg::MODE_KEY, 6'd0, 8'hFF, lgmt_pkg::SPEED_1000, 1'b1);
        // fill group 1 with a duplicated port, then overflow it
        for (int k = 0; k < NSLOTS; k++)
            queue_cmd(lgmt_pkg::MODE_ADD, 6'd1, 8'h09, 14'h0, 1'b0);
        queue_cmd(lgmt_pkg::MODE_DEL, 6'd0, 8'h09, 14'h0, 1'b0);
        queue_cmd(lgmt_pkg::MODE_KEY, 6'd0, 8'h09, lgmt_pkg::SPEED_10000, 1'b1);
        queue_cmd(MODE_UNUSED, 6'd63, 8'hFF, 14'h3FFF, 1'b1);
        queue_cmd(lgmt_pkg::MODE_DEL, 6'd0, 8'hFF, 14'h0, 1'b0);
        queue_cmd(lgmt_pkg::MODE_KEY, 6'd0, 8'hFF, lgmt_pkg::SPEED_10, 1'b1);
        queue_hold();

        // random: a small port pool and a few hot groups so adds, deletes and
        // lookups keep hitting each other
        pool[0] = 8'h00;
        pool[1] = 8'hFF;
        for (int k = 2; k < 16; k++) pool[k] = lgmt_pkg::PORT_W'($urandom);
        hot[0] = 6'd1; hot[1] = 6'd2; hot[2] = 6'd16; hot[3] = 6'd32;
        known[0] = lgmt_pkg::SPEED_10; known[1] = lgmt_pkg::SPEED_100;
        known[2] = lgmt_pkg::SPEED_1000; known[3] = lgmt_pkg::SPEED_10000;

        for (int i = 0; i < RANDOM_CMDS; i++) begin
            if (i == 380) queue_hold();
            add_share = ((i / 100) % 2 == 0) ? 55 : 30;
            p = ($urandom_range(0, 99) < 78) ? pool[$urandom_range(0, 15)]
                                              : lgmt_pkg::PORT_W'($urandom);
            g = lgmt_pkg::GID_W'($urandom);
            s = lgmt_pkg::SPEED_W'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                queue_cmd(MODE_UNUSED, g, lgmt_pkg::PORT_W'($urandom), s, 1'($urandom));
            end else if (roll < add_share) begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    g = hot[$urandom_range(0, 3)];
                else if (pick < 90)
                    g = lgmt_pkg::GID_W'($urandom_range(1, NGROUPS));
                else
                    g = $urandom_range(0, 1) ? lgmt_pkg::GID_W'(0)
                                             : lgmt_pkg::GID_W'($urandom_range(33, 63));
                queue_cmd(lgmt_pkg::MODE_ADD, g, p, s, 1'($urandom));
            end else if (roll < add_share + 25) begin
                queue_cmd(lgmt_pkg::MODE_DEL, g, p, s, 1'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    s = known[$urandom_range(0, 3)];
                else if (pick < 65)
                    s = '0;
                queue_cmd(lgmt_pkg::MODE_KEY, g, p, s, 1'($urandom));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != total_cmds) @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d transactions: %0d add, %0d delete, %0d key, %0d unused mode",
                 n_accepted, n_add, n_del, n_key, n_unused);
        $display("saw %0d full groups, %0d ports not found, %0d key lookups that hit",
                 n_full, n_not_found, n_key_hit);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
